[hw/rtl/zps_pkg.sv]
// Types and constants shared by the radio module probe sequencer.
package zps_pkg;

    localparam int unsigned OpW    = 4;
    localparam int unsigned CmdW   = 4;
    localparam int unsigned PanW   = 16;
    localparam int unsigned PhaseW = 3;
    localparam int unsigned RetryW = 3;
    localparam int unsigned CfgIdxW = 2;

    // Event codes
    localparam logic [OpW-1:0] OP_START        = 4'd0;
    localparam logic [OpW-1:0] OP_BAUD_OK      = 4'd1;
    localparam logic [OpW-1:0] OP_BAUD_SET     = 4'd2;
    localparam logic [OpW-1:0] OP_TYPE_READ    = 4'd3;
    localparam logic [OpW-1:0] OP_TYPE_WRITTEN = 4'd4;
    localparam logic [OpW-1:0] OP_PAN_READ     = 4'd5;
    localparam logic [OpW-1:0] OP_PAN_WRITTEN  = 4'd6;
    localparam logic [OpW-1:0] OP_ERROR        = 4'd7;
    localparam logic [OpW-1:0] OP_TIMER        = 4'd8;

    // Command codes
    localparam logic [CmdW-1:0] CMD_NONE       = 4'd0;
    localparam logic [CmdW-1:0] CMD_TEST_BAUD  = 4'd1;
    localparam logic [CmdW-1:0] CMD_READ_TYPE  = 4'd2;
    localparam logic [CmdW-1:0] CMD_WRITE_TYPE = 4'd3;
    localparam logic [CmdW-1:0] CMD_READ_PAN   = 4'd4;
    localparam logic [CmdW-1:0] CMD_WRITE_PAN  = 4'd5;
    localparam logic [CmdW-1:0] CMD_SET_9600   = 4'd6;
    localparam logic [CmdW-1:0] CMD_RESTART    = 4'd7;
    localparam logic [CmdW-1:0] CMD_WAIT       = 4'd8;
    localparam logic [CmdW-1:0] CMD_FOUND      = 4'd9;
    localparam logic [CmdW-1:0] CMD_NOT_FOUND  = 4'd10;

    // Probe phases
    localparam logic [PhaseW-1:0] PH_IDLE      = 3'd0;
    localparam logic [PhaseW-1:0] PH_TEST9600  = 3'd1;
    localparam logic [PhaseW-1:0] PH_TEST38400 = 3'd2;
    localparam logic [PhaseW-1:0] PH_GET_TYPE  = 3'd3;
    localparam logic [PhaseW-1:0] PH_SET_TYPE  = 3'd4;
    localparam logic [PhaseW-1:0] PH_GET_PAN   = 3'd5;
    localparam logic [PhaseW-1:0] PH_SET_PAN   = 3'd6;
    localparam logic [PhaseW-1:0] PH_SET_BAUD  = 3'd7;

    // Link rate select
    localparam logic BAUD_9600  = 1'b0;
    localparam logic BAUD_38400 = 1'b1;

    // Device types
    localparam logic TYPE_ROUTER = 1'b0;
    localparam logic TYPE_COORD  = 1'b1;

    // PAN ID values of note
    localparam logic [PanW-1:0] PAN_ANY       = 16'hFFFF;
    localparam logic [PanW-1:0] PAN_UNJOINED  = 16'hFFFE;
    localparam logic [PanW-1:0] PAN_COORD_REF = 16'h199B;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_ADJUST_ENABLE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_TARGET_TYPE   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PAN_TARGET    = 2'd2;

    typedef struct packed {
        logic [OpW-1:0]  operation;
        logic            reported_type;
        logic [PanW-1:0] reported_pan_id;
    } t_in_item;

    typedef struct packed {
        logic [CmdW-1:0] command;
        logic            link_baud;
        logic [PanW-1:0] command_value;
    } t_out_item;

    typedef struct packed {
        logic            adjust_enable;
        logic            target_type;
        logic [PanW-1:0] pan_id_target;
    } t_cfg;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [RetryW-1:0] retries_left;
    } t_seq_state;

endpackage

[hw/rtl/zps_cfg.sv]
// Configuration registers of the probe sequencer.
module zps_cfg
    import zps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [PanW-1:0]    i_cfg_wdata,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADJUST_ENABLE: n_cfg.adjust_enable = i_cfg_wdata[0];
                CFG_TARGET_TYPE: begin
                    n_cfg.target_type = i_cfg_wdata[0];
                    // router has no PAN of its own to impose
                    if (i_cfg_wdata[0] == TYPE_ROUTER) begin
                        n_cfg.pan_id_target = PAN_ANY;
                    end
                end
                CFG_PAN_TARGET: n_cfg.pan_id_target = i_cfg_wdata;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adjust_enable <= 1'b0;
            r_cfg.target_type   <= TYPE_ROUTER;
            r_cfg.pan_id_target <= PAN_ANY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/zps_decide.sv]
// Per-event decision: command and next probe state.
module zps_decide
    import zps_pkg::*;
#(
    parameter int RETRY_LIMIT = 5
) (
    input  t_cfg       i_cfg,
    input  t_in_item   i_item,
    input  t_seq_state i_state,
    output t_out_item  o_result,
    output t_seq_state o_state
);

    localparam logic [RetryW-1:0] RetryLoad = RetryW'(RETRY_LIMIT);

    logic pan_rewrite;

    always_comb begin
        pan_rewrite = 1'b0;
        if (i_cfg.adjust_enable) begin
            if (i_cfg.target_type == TYPE_COORD) begin
                pan_rewrite = (i_cfg.pan_id_target != PAN_ANY) &&
                              (i_item.reported_pan_id != PAN_COORD_REF);
            end else begin
                pan_rewrite = (i_item.reported_pan_id != PAN_UNJOINED);
            end
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '{command: CMD_NONE, link_baud: BAUD_9600, command_value: '0};
        unique case (i_item.operation) inside
            OP_START: begin
                o_state.retries_left = RetryLoad;
                o_state.phase        = PH_TEST9600;
                o_result.command     = CMD_TEST_BAUD;
            end
            OP_BAUD_OK: begin
                if (!i_cfg.adjust_enable || i_state.phase == PH_TEST9600) begin
                    o_state.phase    = PH_GET_TYPE;
                    o_result.command = CMD_READ_TYPE;
                end else if (i_state.phase == PH_TEST38400) begin
                    o_state.phase    = PH_SET_BAUD;
                    o_result.command = CMD_SET_9600;
                end
            end
            OP_BAUD_SET, OP_TYPE_WRITTEN, OP_PAN_WRITTEN: begin
                o_result.command = CMD_RESTART;
            end
            OP_TYPE_READ: begin
                if (!i_cfg.adjust_enable || i_item.reported_type == i_cfg.target_type) begin
                    o_state.phase    = PH_GET_PAN;
                    o_result.command = CMD_READ_PAN;
                end else begin
                    o_state.phase          = PH_SET_TYPE;
                    o_result.command       = CMD_WRITE_TYPE;
                    o_result.command_value = PanW'(i_cfg.target_type);
                end
            end
            OP_PAN_READ: begin
                if (pan_rewrite) begin
                    o_state.phase          = PH_SET_PAN;
                    o_result.command       = CMD_WRITE_PAN;
                    o_result.command_value = i_cfg.pan_id_target;
                end else begin
                    o_result.command = CMD_FOUND;
                end
            end
            OP_ERROR: begin
                if (i_state.retries_left <= RetryW'(1)) begin
                    if (i_state.phase == PH_TEST9600) begin
                        // fall back to the faster link with fresh retries
                        o_state.phase        = PH_TEST38400;
                        o_state.retries_left = RetryLoad;
                        o_result.command     = CMD_TEST_BAUD;
                        o_result.link_baud   = BAUD_38400;
                    end else begin
                        o_state.retries_left = '0;
                        o_result.command     = CMD_NOT_FOUND;
                    end
                end else begin
                    o_state.retries_left = i_state.retries_left - RetryW'(1);
                    o_result.command     = CMD_WAIT;
                end
            end
            OP_TIMER: begin
                o_result.command = CMD_TEST_BAUD;
                if (i_state.phase != PH_TEST38400) begin
                    o_state.phase = PH_TEST9600;
                end else begin
                    o_result.link_baud = BAUD_38400;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

[hw/rtl/zigbee_module_probe_sequencer.sv]
// Top level of the radio module probe sequencer.
//
// Usage: each transfer on the input channel (i_in_valid / o_in_stall,
// payload i_in_data) carries one event from the serial link or the timer.
// Every event yields exactly one command transfer on the output channel
// (o_out_valid / i_out_stall, payload o_out_data), in event order.
// Path: an event taken into the input register is decided from there, and
// its command is registered in the result register that drives o_out_data.
// Throughput: one event per cycle while the receiver does not stall; the
// decision is a single pass of short logic between the input register and
// the result register, and the probe state (phase, retry count) is updated
// in the same cycle as the decision.
// Stall: while the receiver holds i_out_stall the result register keeps its
// command and one further event may wait in the input register; only when
// both are full does o_in_stall rise.
// Reset (i_rst_n low, synchronous): clear both valid flags, return the
// phase to idle with no retries and restore the configuration defaults
// (adjust off, router, PAN ID 0xFFFF).
// Configuration: i_cfg_we writes register i_cfg_idx at once; index 3 is
// ignored. Write only while no event is in flight.
module zigbee_module_probe_sequencer
    import zps_pkg::*;
#(
    parameter int RETRY_LIMIT = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [PanW-1:0]    i_cfg_wdata
);

    t_cfg       cfg;
    t_in_item   r_in;
    logic       r_in_vld;
    logic       n_in_vld;
    t_out_item  r_out;
    logic       r_out_vld;
    logic       n_out_vld;
    t_seq_state r_state;
    t_seq_state n_state;
    t_out_item  dec_result;
    logic       out_free;
    logic       in_xfer;
    logic       dec_adv;

    zps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    zps_decide #(
        .RETRY_LIMIT (RETRY_LIMIT)
    ) u_decide (
        .i_cfg    (cfg),
        .i_item   (r_in),
        .i_state  (r_state),
        .o_result (dec_result),
        .o_state  (n_state)
    );

    // Result register can take a new command when empty or being drained
    assign out_free   = !r_out_vld || !i_out_stall;
    assign dec_adv    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign n_in_vld  = in_xfer || (r_in_vld && !dec_adv);
    assign n_out_vld = dec_adv || (r_out_vld && i_out_stall);

    // Control: valid flags and probe state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld             <= 1'b0;
            r_out_vld            <= 1'b0;
            r_state.phase        <= PH_IDLE;
            r_state.retries_left <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            // advance the probe state only as the event is decided
            if (dec_adv) begin
                r_state <= n_state;
            end
        end
    end

    // Payload: hold while not advancing
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (dec_adv) begin
            r_out <= dec_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/zps_checker.sv]
// Port-level checks for the probe sequencer, bound to the top level.
module zps_checker
    import zps_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input t_out_item          o_out_data
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Input back-pressure only when the output side is full and stalled
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // Fast link rate only accompanies a baud test
    a_baud_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.link_baud |-> o_out_data.command == CMD_TEST_BAUD)
        else $error("link rate set on a command other than test baud");

    // Only writes carry a value, and a type write carries one bit
    a_value_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.command_value != '0 |->
            o_out_data.command == CMD_WRITE_PAN ||
            (o_out_data.command == CMD_WRITE_TYPE &&
             o_out_data.command_value[PanW-1:1] == '0))
        else $error("command value on an unexpected command");

endmodule

bind zigbee_module_probe_sequencer zps_checker u_zps_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the radio module probe sequencer: predicted command stream vs DUT.
module tb_top;
    import zps_pkg::*;

    // Probe retry budget given to the DUT and mirrored in the command predictor
    localparam int RETRIES = 5;
    localparam logic [RetryW-1:0] RETRY_RELOAD = RetryW'(RETRIES);

    // Event codes beyond the defined set; the sequencer must ignore them
    localparam logic [OpW-1:0] OP_UNKNOWN_LO = 4'd9;
    localparam logic [OpW-1:0] OP_UNKNOWN_HI = 4'd15;

    // Register index with no register behind it
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    localparam int HOLDOFF_CYCLES = 300;  // long receiver hold-off to back the pipe up
    localparam int QUIET_LIMIT    = 3000; // cycles without any transfer before giving up
    localparam int TAIL_CYCLES    = 10;   // settle time after the last result
    localparam int SHOW_LIMIT     = 10;   // mismatches printed in full

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_item           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_data;
    logic               cfg_we    = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx   = '0;
    logic [PanW-1:0]    cfg_wdata = '0;

    // Events waiting to be offered, and commands the DUT still owes us
    t_in_item  event_pending[$];
    t_out_item cmd_expected[$];

    // Shadow copy of the configuration and the probe state
    t_cfg              cfg_model    = '{adjust_enable: 1'b0, target_type: TYPE_ROUTER,
                                        pan_id_target: PAN_ANY};
    logic [PhaseW-1:0] probe_phase  = PH_IDLE;
    logic [RetryW-1:0] retries_left = '0;

    // Traffic shaping, set by the sequence block between phases
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holdoff_req   = 0;
    int holdoff_seen  = 0;
    int holdoff_left  = 0;

    int        n_queued   = 0;
    int        n_fail     = 0;
    int        n_shown    = 0;
    int        quiet      = 0;
    t_out_item cmd_wanted;

    zigbee_module_probe_sequencer #(
        .RETRY_LIMIT(RETRIES)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Work out the command for one event and advance the shadow probe state.
    function automatic t_out_item next_command(input t_in_item ev);
        t_out_item res;
        logic      rewrite;
        res = '0;
        case (ev.operation)
            OP_START: begin
                retries_left = RETRY_RELOAD;
                probe_phase  = PH_TEST9600;
                res.command  = CMD_TEST_BAUD;
            end
            OP_BAUD_OK: begin
                if (!cfg_model.adjust_enable || probe_phase == PH_TEST9600) begin
                    probe_phase = PH_GET_TYPE;
                    res.command = CMD_READ_TYPE;
                end else if (probe_phase == PH_TEST38400) begin
                    probe_phase = PH_SET_BAUD;
                    res.command = CMD_SET_9600;
                end else begin
                    res.command = CMD_NONE;
                end
            end
            OP_BAUD_SET, OP_TYPE_WRITTEN, OP_PAN_WRITTEN: begin
                res.command = CMD_RESTART;
            end
            OP_TYPE_READ: begin
                if (!cfg_model.adjust_enable || ev.reported_type == cfg_model.target_type) begin
                    probe_phase = PH_GET_PAN;
                    res.command = CMD_READ_PAN;
                end else begin
                    probe_phase       = PH_SET_TYPE;
                    res.command       = CMD_WRITE_TYPE;
                    res.command_value = {{(PanW-1){1'b0}}, cfg_model.target_type};
                end
            end
            OP_PAN_READ: begin
                rewrite = cfg_model.adjust_enable;
                if (rewrite) begin
                    // a coordinator with a wildcard target is left alone
                    if (cfg_model.target_type == TYPE_COORD) begin
                        rewrite = cfg_model.pan_id_target != PAN_ANY &&
                                  ev.reported_pan_id != PAN_COORD_REF;
                    end else begin
                        rewrite = ev.reported_pan_id != PAN_UNJOINED;
                    end
                end
                if (rewrite) begin
                    probe_phase       = PH_SET_PAN;
                    res.command       = CMD_WRITE_PAN;
                    res.command_value = cfg_model.pan_id_target;
                end else begin
                    res.command = CMD_FOUND;
                end
            end
            OP_ERROR: begin
                if (retries_left <= 1) begin
                    if (probe_phase == PH_TEST9600) begin
                        probe_phase   = PH_TEST38400;
                        retries_left  = RETRY_RELOAD;
                        res.command   = CMD_TEST_BAUD;
                        res.link_baud = BAUD_38400;
                    end else begin
                        retries_left = '0;
                        res.command  = CMD_NOT_FOUND;
                    end
                end else begin
                    retries_left = retries_left - 1'b1;
                    res.command  = CMD_WAIT;
                end
            end
            OP_TIMER: begin
                res.command = CMD_TEST_BAUD;
                if (probe_phase == PH_TEST38400) begin
                    res.link_baud = BAUD_38400;
                end else begin
                    probe_phase = PH_TEST9600;
                end
            end
            default: begin
                res.command = CMD_NONE;
            end
        endcase
        return res;
    endfunction

    // Driver: predict each event as its transfer completes, then offer the next one.
    // A stalled event is held untouched; valid only drops once the transfer is done.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                cmd_expected.push_back(next_command(in_data));
            end
            if (!in_valid || !in_stall) begin
                if (event_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_data  <= event_pending.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each command transfer against the oldest prediction and
    // decide the stall for the next cycle. A hold-off request wins over the random stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (cmd_expected.size() == 0) begin
                    n_fail++;
                    if (n_shown < SHOW_LIMIT) begin
                        n_shown++;
                        $display("unexpected command: cmd %0d baud %0d value %h",
                                 out_data.command, out_data.link_baud, out_data.command_value);
                    end
                end else begin
                    cmd_wanted = cmd_expected.pop_front();
                    if (out_data.command !== cmd_wanted.command ||
                        out_data.link_baud !== cmd_wanted.link_baud ||
                        out_data.command_value !== cmd_wanted.command_value) begin
                        n_fail++;
                        if (n_shown < SHOW_LIMIT) begin
                            n_shown++;
                            $display({"command mismatch: expected cmd %0d baud %0d value %h,",
                                      " got cmd %0d baud %0d value %h"},
                                     cmd_wanted.command, cmd_wanted.link_baud,
                                     cmd_wanted.command_value, out_data.command,
                                     out_data.link_baud, out_data.command_value);
                        end
                    end
                end
            end
            if (holdoff_seen != holdoff_req) begin
                holdoff_seen <= holdoff_req;
                holdoff_left <= HOLDOFF_CYCLES;
                out_stall    <= 1'b1;
            end else if (holdoff_left != 0) begin
                holdoff_left <= holdoff_left - 1;
                out_stall    <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Watchdog: give up once no transfer has happened on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic add_event(input logic [OpW-1:0] op, input logic rtype,
                             input logic [PanW-1:0] pan);
        t_in_item ev;
        ev.operation       = op;
        ev.reported_type   = rtype;
        ev.reported_pan_id = pan;
        event_pending.push_back(ev);
        n_queued++;
    endtask

    // Queue one event of a session, now and then preceded by a stray one.
    task automatic add_op(input logic [OpW-1:0] op, input logic [PanW-1:0] pan);
        if ($urandom_range(0, 9) == 0) begin
            add_event(OpW'($urandom), 1'($urandom), 16'($urandom));
        end
        add_event(op, 1'($urandom), pan);
    endtask

    // Bias PAN ID reads towards the values the sequencer tests for.
    function automatic logic [PanW-1:0] pick_pan();
        case ($urandom_range(0, 3))
            0:       return PAN_COORD_REF;
            1:       return PAN_UNJOINED;
            2:       return PAN_ANY;
            default: return 16'($urandom);
        endcase
    endfunction

    // One probe session as the module would answer it: start, some errors
    // (possibly through the fallback and past exhaustion), baud ok, type and
    // PAN ID checks with optional write/restart loops. Some sessions break off early.
    task automatic add_session();
        add_op(OP_START, 16'($urandom));
        repeat ($urandom_range(0, 12)) add_op(OP_ERROR, 16'($urandom));
        if ($urandom_range(0, 4) == 0) return;
        if ($urandom_range(0, 3) == 0) add_op(OP_TIMER, 16'($urandom));
        add_op(OP_BAUD_OK, 16'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            add_op(OP_BAUD_SET, 16'($urandom));
            add_op(OP_TIMER, 16'($urandom));
            add_op(OP_BAUD_OK, 16'($urandom));
        end
        add_op(OP_TYPE_READ, 16'($urandom));
        if ($urandom_range(0, 1) == 0) begin
            add_op(OP_TYPE_WRITTEN, 16'($urandom));
            add_op(OP_TIMER, 16'($urandom));
            add_op(OP_BAUD_OK, 16'($urandom));
            add_op(OP_TYPE_READ, 16'($urandom));
        end
        add_op(OP_PAN_READ, pick_pan());
        if ($urandom_range(0, 1) == 0) begin
            add_op(OP_PAN_WRITTEN, 16'($urandom));
            add_op(OP_TIMER, 16'($urandom));
            add_op(OP_BAUD_OK, 16'($urandom));
            add_op(OP_TYPE_READ, 16'($urandom));
            add_op(OP_PAN_READ, pick_pan());
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) add_op(OP_ERROR, 16'($urandom));
        end
    endtask

    task automatic fill(input int items);
        int stop;
        stop = n_queued + items;
        while (n_queued < stop) add_session();
    endtask

    // Hold the sender back until every queued event has been answered.
    task automatic drain();
        do @(negedge clk);
        while (event_pending.size() != 0 || in_valid || cmd_expected.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Register write; only ever called with nothing in flight.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PanW-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ADJUST_ENABLE: cfg_model.adjust_enable = val[0];
            CFG_TARGET_TYPE: begin
                cfg_model.target_type = val[0];
                if (val[0] == TYPE_ROUTER) cfg_model.pan_id_target = PAN_ANY;
            end
            CFG_PAN_TARGET:    cfg_model.pan_id_target = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset configuration (no adjusting)
        add_event(OP_ERROR, TYPE_ROUTER, 16'h0000);       // error before any start
        add_event(OP_TIMER, TYPE_COORD, PAN_ANY);         // timer outside a wait
        add_event(OP_START, TYPE_ROUTER, PAN_ANY);
        repeat (5) add_event(OP_ERROR, TYPE_COORD, 16'h0000); // run out, fall back to 38400
        add_event(OP_TIMER, TYPE_ROUTER, 16'h0000);       // retest stays at 38400
        add_event(OP_BAUD_OK, TYPE_COORD, PAN_ANY);
        add_event(OP_TYPE_READ, TYPE_COORD, 16'h0000);
        add_event(OP_PAN_READ, TYPE_ROUTER, 16'h0000);
        add_event(OP_UNKNOWN_LO, TYPE_COORD, PAN_ANY);
        add_event(OP_UNKNOWN_HI, TYPE_ROUTER, 16'h0000);
        add_event(OP_BAUD_SET, TYPE_COORD, PAN_ANY);
        add_event(OP_TYPE_WRITTEN, TYPE_ROUTER, PAN_ANY);
        add_event(OP_PAN_WRITTEN, TYPE_COORD, 16'h0000);
        drain();

        // Directed, adjusting towards a coordinator on a fixed PAN ID
        write_reg(CFG_ADJUST_ENABLE, 16'h0001);
        write_reg(CFG_TARGET_TYPE, 16'hFFFF);
        write_reg(CFG_PAN_TARGET, 16'h1234);
        add_event(OP_BAUD_OK, TYPE_ROUTER, 16'h0000);     // baud ok outside a baud test
        add_event(OP_TYPE_READ, TYPE_ROUTER, PAN_ANY);    // wrong type: rewrite
        add_event(OP_PAN_READ, TYPE_COORD, PAN_COORD_REF);
        add_event(OP_PAN_READ, TYPE_ROUTER, PAN_ANY);     // wrong PAN ID: rewrite
        add_event(OP_TIMER, TYPE_COORD, 16'h0000);
        add_event(OP_BAUD_OK, TYPE_ROUTER, PAN_ANY);
        drain();

        // Random, no idling, router target; one long receiver hold-off
        write_reg(CFG_TARGET_TYPE, {15'($urandom), TYPE_ROUTER});
        send_idle_pct = 0;
        stall_pct     = 0;
        fill(330);
        holdoff_req++;
        drain();

        // Random, sender idling, coordinator with wildcard PAN ID; pause halfway
        write_reg(CFG_TARGET_TYPE, {15'($urandom), TYPE_COORD});
        write_reg(CFG_PAN_TARGET, PAN_ANY);
        send_idle_pct = 64;
        stall_pct     = 0;
        fill(165);
        drain();
        fill(165);
        drain();

        // Random, receiver stalling, adjusting off
        write_reg(CFG_ADJUST_ENABLE, {15'($urandom), 1'b0});
        write_reg(CFG_PAN_TARGET, 16'h0000);
        send_idle_pct = 0;
        stall_pct     = 64;
        fill(330);
        drain();

        // Random, both sides idling, adjusting on to a random PAN ID
        write_reg(CFG_ADJUST_ENABLE, {15'($urandom), 1'b1});
        write_reg(CFG_PAN_TARGET, 16'($urandom));
        write_reg(CFG_UNUSED, 16'($urandom));
        send_idle_pct = 30;
        stall_pct     = 30;
        fill(330);
        drain();

        if (n_fail == 0 && cmd_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
